// File: design/single_wire_sensor_frame_decoder_assert.svh
// Assertion macros used by the sensor frame decoder RTL.
`ifndef SINGLE_WIRE_SENSOR_FRAME_DECODER_ASSERT_SVH
`define SINGLE_WIRE_SENSOR_FRAME_DECODER_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define SWFD_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("swfd assertion failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define SWFD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("swfd assertion failed");

`endif

// File: design/swfd_pkg.sv
// Types and constants of the single-wire sensor frame decoder.
`default_nettype none

package swfd_pkg;

   localparam int TIMER_WIDTH = 16;
   localparam int COUNT_WIDTH = 6;
   localparam int DATA_BITS = 32;
   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;

   localparam logic [15:0] BIT_THRESHOLD_RESET = 16'd110;
   localparam logic [COUNT_WIDTH-1:0] FRAME_EDGES_RESET = 6'd40;
   localparam logic [COUNT_WIDTH-1:0] EDGE_MAX = 6'd63;
   localparam logic [7:0] HUMIDITY_MAX = 8'd99;
   localparam logic [7:0] DIGIT_BASE = 8'd48;

   // Input action codes.
   typedef enum logic {
      ACTION_START   = 1'b0,
      ACTION_CAPTURE = 1'b1
   } action_type;

   // Register index, taken from paddr bit 2.
   typedef enum logic {
      CSR_BIT_THRESHOLD = 1'b0,
      CSR_FRAME_EDGES   = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic        action;
      logic [15:0] timestamp;
   } req_type;

   typedef struct packed {
      logic [7:0]  humidity_int;
      logic [7:0]  humidity_frac;
      logic [7:0]  temperature_int;
      logic [7:0]  temperature_frac;
      logic [63:0] ascii_text;
   } rsp_type;

   // Decoded frame bytes handed to the text stage.
   typedef struct packed {
      logic [7:0] humidity_int;
      logic [7:0] humidity_frac;
      logic [7:0] temperature_int;
      logic [7:0] temperature_frac;
   } frame_bytes_type;

endpackage

`default_nettype wire

// File: design/single_wire_sensor_frame_decoder.sv
// Top level of the single-wire sensor frame decoder.
//
//   Port group   Direction  Transaction
//   req_*        in         start action or falling-edge timer capture
//   rsp_*        out        decoded frame bytes and ASCII text
//   APB (p*)     in/out     bit_threshold at 0x0, frame_edges at 0x4
//
// One transaction is accepted per cycle when not stalled; the input register
// and the result register form a two-stage pipeline with the decode and text
// logic between; each result is registered in the input, then the result stage.
// Reset is synchronous and clears all frame state and the valid flags.
// A stalled result holds the pipeline; req_ready drops only when a completing
// capture cannot move into a full result stage.
`default_nettype none

module single_wire_sensor_frame_decoder (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_valid,
   output logic                                 req_ready,
   input  wire swfd_pkg::req_type               req_data,
   output logic                                 rsp_valid,
   input  wire                                  rsp_ready,
   output swfd_pkg::rsp_type                    rsp_data,
   input  wire                                  psel,
   input  wire                                  penable,
   input  wire                                  pwrite,
   input  wire [swfd_pkg::CSR_ADDR_WIDTH-1:0]   paddr,
   input  wire [swfd_pkg::CSR_DATA_WIDTH-1:0]   pwdata,
   output logic [swfd_pkg::CSR_DATA_WIDTH-1:0]  prdata,
   output logic                                 pready
);
   import swfd_pkg::*;

   `include "single_wire_sensor_frame_decoder_assert.svh"

   logic [15:0]            bit_threshold_ff;
   logic [COUNT_WIDTH-1:0] frame_edges_ff;

   logic [TIMER_WIDTH-1:0] previous_stamp_ff, previous_stamp_in;
   logic [COUNT_WIDTH-1:0] edge_count_ff, edge_count_in;
   logic [DATA_BITS-1:0]   bit_shift_ff, bit_shift_in;
   logic                   frame_done_ff, frame_done_in;

   logic                   s1_valid_ff;
   req_type                s1_data_ff;
   rsp_type                s2_data_ff;
   logic                   s2_valid_ff;

   logic                   csr_write;
   csr_index_type          csr_index;
   logic                   s1_adv, s2_open;
   logic                   emit;
   logic [TIMER_WIDTH-1:0] stamp, interval;
   logic                   data_bit, take_bit;
   logic [DATA_BITS-1:0]   shift_next;
   logic [COUNT_WIDTH-1:0] count_next;
   frame_bytes_type        bytes_next;
   logic [63:0]            ascii_text;

   // Configuration port: always ready, register picked by paddr bit 2.
   assign pready    = 1'b1;
   assign csr_index = csr_index_type'(paddr[2]);
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      unique case (csr_index)
         CSR_BIT_THRESHOLD: prdata = CSR_DATA_WIDTH'(bit_threshold_ff);
         CSR_FRAME_EDGES:   prdata = CSR_DATA_WIDTH'(frame_edges_ff);
         default:           prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_threshold_ff <= BIT_THRESHOLD_RESET;
         frame_edges_ff   <= FRAME_EDGES_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_BIT_THRESHOLD: bit_threshold_ff <= pwdata[15:0];
            CSR_FRAME_EDGES:   frame_edges_ff   <= pwdata[COUNT_WIDTH-1:0];
            default:           bit_threshold_ff <= bit_threshold_ff;
         endcase
      end
   end

   // Interval decode, bit shift and frame completion for the item in stage 1.
   assign stamp      = s1_data_ff.timestamp[TIMER_WIDTH-1:0];
   assign interval   = stamp - previous_stamp_ff;
   assign data_bit   = (interval >= bit_threshold_ff);
   assign take_bit   = (edge_count_ff != '0) && (edge_count_ff <= COUNT_WIDTH'(DATA_BITS));
   assign shift_next = take_bit ? {bit_shift_ff[DATA_BITS-2:0], data_bit} : bit_shift_ff;
   assign count_next = (edge_count_ff < EDGE_MAX) ? edge_count_ff + COUNT_WIDTH'(1)
                       : edge_count_ff;
   assign emit       = (s1_data_ff.action == ACTION_CAPTURE) && !frame_done_ff
                       && (count_next >= frame_edges_ff);

   // Humidity bytes are clamped; temperature bytes pass as decoded.
   always_comb begin
      bytes_next.humidity_int = (shift_next[31:24] > HUMIDITY_MAX) ? HUMIDITY_MAX
                                : shift_next[31:24];
      bytes_next.humidity_frac = (shift_next[23:16] > HUMIDITY_MAX) ? HUMIDITY_MAX
                                 : shift_next[23:16];
      bytes_next.temperature_int  = shift_next[15:8];
      bytes_next.temperature_frac = shift_next[7:0];
   end

   // Pipeline flow control.
   assign s2_open   = !s2_valid_ff || rsp_ready;
   assign s1_adv    = s1_valid_ff && (!emit || s2_open);
   assign req_ready = !s1_valid_ff || s1_adv;

   // Next frame state for the item leaving stage 1.
   always_comb begin
      previous_stamp_in = previous_stamp_ff;
      edge_count_in     = edge_count_ff;
      bit_shift_in      = bit_shift_ff;
      frame_done_in     = frame_done_ff;
      if (s1_adv) begin
         if (s1_data_ff.action == ACTION_START) begin
            previous_stamp_in = '0;
            edge_count_in     = '0;
            bit_shift_in      = '0;
            frame_done_in     = 1'b0;
         end else if (!frame_done_ff) begin
            previous_stamp_in = stamp;
            edge_count_in     = count_next;
            bit_shift_in      = shift_next;
            frame_done_in     = emit;
         end
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         previous_stamp_ff <= '0;
         edge_count_ff     <= '0;
         bit_shift_ff      <= '0;
         frame_done_ff     <= 1'b0;
         s1_valid_ff       <= 1'b0;
         s2_valid_ff       <= 1'b0;
      end else begin
         previous_stamp_ff <= previous_stamp_in;
         edge_count_ff     <= edge_count_in;
         bit_shift_ff      <= bit_shift_in;
         frame_done_ff     <= frame_done_in;
         if (req_ready) begin
            s1_valid_ff <= req_valid;
         end
         if (s2_open) begin
            s2_valid_ff <= s1_adv && emit;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         s1_data_ff <= req_data;
      end
      if (s1_adv && emit) begin
         s2_data_ff.humidity_int     <= bytes_next.humidity_int;
         s2_data_ff.humidity_frac    <= bytes_next.humidity_frac;
         s2_data_ff.temperature_int  <= bytes_next.temperature_int;
         s2_data_ff.temperature_frac <= bytes_next.temperature_frac;
         s2_data_ff.ascii_text       <= ascii_text;
      end
   end

   swfd_ascii u_ascii (
      .frame_bytes (bytes_next),
      .ascii_text  (ascii_text)
   );

   assign rsp_valid = s2_valid_ff;
   assign rsp_data  = s2_data_ff;

   // A frame result marks the frame as done.
   `SWFD_ASSERT_NEXT(a_emit_sets_done, clock, reset, s1_adv && emit, frame_done_ff)
   // A capture never lowers the edge count.
   `SWFD_ASSERT_NEXT(a_count_grows, clock, reset,
      s1_adv && (s1_data_ff.action == ACTION_CAPTURE),
      edge_count_ff >= $past(edge_count_ff))
   // An empty frame holds no data bits.
   `SWFD_ASSERT_SAME(a_empty_frame, clock, reset,
      edge_count_ff == '0, bit_shift_ff == '0)
   // Humidity bytes on the result never exceed the clamp.
   `SWFD_ASSERT_SAME(a_humidity_clamp, clock, reset, rsp_valid,
      (rsp_data.humidity_int <= HUMIDITY_MAX) && (rsp_data.humidity_frac <= HUMIDITY_MAX))

endmodule

`default_nettype wire

// File: design/swfd_ascii.sv
// Converts the four frame bytes to eight ASCII characters, two per byte.
`default_nettype none

module swfd_ascii (
   input  wire swfd_pkg::frame_bytes_type frame_bytes,
   output logic [63:0]                    ascii_text
);
   import swfd_pkg::*;

   // Tens and ones characters of one byte; divide by ten via reciprocal 205/2048.
   function automatic logic [15:0] two_digits(input logic [7:0] value);
      logic [15:0] product;
      logic [7:0]  tens;
      logic [7:0]  ones;
      begin
         product = 16'(value) * 16'd205;
         tens = {3'b000, product[15:11]};
         ones = 8'(value - 8'(tens * 8'd10));
         two_digits = {8'(tens + DIGIT_BASE), 8'(ones + DIGIT_BASE)};
      end
   endfunction

   // Temperature first, humidity last, first character in the top byte.
   assign ascii_text = {two_digits(frame_bytes.temperature_int),
                        two_digits(frame_bytes.temperature_frac),
                        two_digits(frame_bytes.humidity_int),
                        two_digits(frame_bytes.humidity_frac)};

endmodule

`default_nettype wire
